// File: sv/pit_pkg.sv
// Package for the pausable interval timer.
// Holds the request codes, register indexes, default widths and the
// status struct of the modulo unit. Depends on nothing.
`default_nettype none

package pit_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int STEP_WIDTH_DEF = 16;
  localparam int REQ_WIDTH      = 3;
  localparam int OUT_WIDTH      = 32;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_IDX_WIDTH  = 1;

  localparam logic [REQ_WIDTH-1:0] REQ_ADVANCE = 3'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_START   = 3'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_STOP    = 3'd2;
  localparam logic [REQ_WIDTH-1:0] REQ_PAUSE   = 3'd3;
  localparam logic [REQ_WIDTH-1:0] REQ_RESUME  = 3'd4;
  localparam logic [REQ_WIDTH-1:0] REQ_RESET   = 3'd5;
  localparam logic [REQ_WIDTH-1:0] REQ_TICK    = 3'd6;
  localparam logic [REQ_WIDTH-1:0] REQ_LAP     = 3'd7;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_REPEAT   = 1'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } pit_div_stat_t;

endpackage

`default_nettype wire

// File: sv/pit_mod_unit.sv
// Bit-serial modulo unit of the pausable interval timer.
// Produces dividend mod divisor with one restoring subtract per cycle.
// Depends on pit_pkg for its status struct.
`default_nettype none

module pit_mod_unit
  import pit_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [TIME_WIDTH-1:0] dividend,
  input  wire logic [TIME_WIDTH-1:0] divisor,
  output logic [TIME_WIDTH-1:0]      remainder,
  output pit_div_stat_t              stat
);

  localparam int CW = $clog2(TIME_WIDTH);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [TIME_WIDTH-1:0] dsr_r, dsr_nxt;
  logic [TIME_WIDTH-1:0] rem_r, rem_nxt;
  logic [TIME_WIDTH:0]   trial;
  logic [TIME_WIDTH:0]   diff;

  assign trial = {rem_r, dvd_r[TIME_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TIME_WIDTH-2:0], 1'b0};
      rem_nxt = diff[TIME_WIDTH] ? trial[TIME_WIDTH-1:0] : diff[TIME_WIDTH-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(TIME_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: sv/pausable_interval_timer.sv
// Top level of the pausable interval timer: request sequencer and state.
// Depends on pit_pkg and uses pit_mod_unit for the interval remainder.
//
// Usage: requests (advance, start, stop, pause, resume, reset, tick, lap)
// arrive on the in_ channel with valid and ready; each item yields exactly
// one result item on the out_ channel with valid and ready. The cfg_ port
// writes interval_ticks (index 0) and repeat_mode (index 1); the user must
// use it only while the timer is idle, as the block does not enforce this,
// and either write clears the interval progress.
// Sequencing: the block takes one item at a time. A plain item goes
// from idle through the execute and done states; its result is loaded
// into the output register as the block returns to idle and is ready
// again. An advance that completes an interval in periodic mode passes
// through the divide state between execute and done and runs the
// bit-serial modulo unit there, one remainder bit per cycle.
// The result sits in an output register; when the receiver stalls, the
// next item may still be accepted and worked on, and it waits before
// its own result is loaded until the register frees up.
// Reset: synchronous, active low; state, counters, run and pause flags
// and settings clear and no result is pending; others are not reset.
`default_nettype none

module pausable_interval_timer
  import pit_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [REQ_WIDTH-1:0]      in_req_type,
  input  wire logic [STEP_WIDTH-1:0]     in_time_step,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [OUT_WIDTH-1:0]           out_elapsed,
  output logic [OUT_WIDTH-1:0]           out_delta,
  output logic                           out_fired,
  output logic                           out_is_running,
  output logic                           out_is_paused,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  localparam int SXW = (STEP_WIDTH > TIME_WIDTH) ? STEP_WIDTH : TIME_WIDTH;
  localparam int CXW = (CFG_DATA_WIDTH > TIME_WIDTH) ? CFG_DATA_WIDTH : TIME_WIDTH;
  localparam int OXW = (OUT_WIDTH > TIME_WIDTH) ? OUT_WIDTH : TIME_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
  endfunction

  logic [1:0]            state_r, state_nxt;
  logic [REQ_WIDTH-1:0]  req_r;
  logic [TIME_WIDTH-1:0] dt_r;
  logic [SXW-1:0]        step_x;
  logic [CXW-1:0]        cfg_x;

  logic                  run_r, run_nxt;
  logic                  pause_r, pause_nxt;
  logic [TIME_WIDTH-1:0] banked_r, banked_nxt;
  logic [TIME_WIDTH-1:0] seg_r, seg_nxt;
  logic [TIME_WIDTH-1:0] tick_r, tick_nxt;
  logic [TIME_WIDTH-1:0] lap_r, lap_nxt;
  logic [TIME_WIDTH-1:0] prog_r, prog_nxt;
  logic [TIME_WIDTH-1:0] interval_r;
  logic                  repeat_r;
  logic [TIME_WIDTH-1:0] delta_r, delta_nxt;
  logic                  fired_r, fired_nxt;
  logic [TIME_WIDTH-1:0] prog_sum;

  logic                  div_start;
  logic [TIME_WIDTH-1:0] div_rem;
  pit_div_stat_t         div_stat;

  logic                  live;
  logic [TIME_WIDTH-1:0] elapsed_now;
  logic [OXW-1:0]        elapsed_x;
  logic [OXW-1:0]        delta_x;
  logic                  out_valid_r;
  logic [OUT_WIDTH-1:0]  out_elapsed_r, out_delta_r;
  logic                  out_fired_r, out_running_r, out_paused_r;
  logic                  in_fire;
  logic                  load_out;

  assign step_x   = SXW'(in_time_step);
  assign cfg_x    = CXW'(cfg_data);
  assign in_ready = (state_r == ST_IDLE) && !div_stat.busy;
  assign in_fire  = in_valid && in_ready;
  assign live     = run_r && !pause_r;
  assign prog_sum = sat_add(prog_r, dt_r);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    run_nxt    = run_r;
    pause_nxt  = pause_r;
    banked_nxt = banked_r;
    seg_nxt    = seg_r;
    tick_nxt   = tick_r;
    lap_nxt    = lap_r;
    prog_nxt   = prog_r;
    delta_nxt  = delta_r;
    fired_nxt  = fired_r;
    div_start  = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        delta_nxt = '0;
        fired_nxt = 1'b0;
        state_nxt = ST_DONE;
        unique case (req_r)
          REQ_ADVANCE: begin
            lap_nxt = sat_add(lap_r, dt_r);
            if (live) begin
              seg_nxt  = sat_add(seg_r, dt_r);
              tick_nxt = sat_add(tick_r, dt_r);
              if (interval_r != '0) begin
                prog_nxt = prog_sum;
                if (prog_sum >= interval_r) begin
                  fired_nxt = 1'b1;
                  if (repeat_r) begin
                    div_start = 1'b1;
                    state_nxt = ST_DIV;
                  end else begin
                    run_nxt  = 1'b0;
                    prog_nxt = '0;
                  end
                end
              end
            end
          end
          REQ_START: begin
            run_nxt    = 1'b1;
            pause_nxt  = 1'b0;
            banked_nxt = '0;
            prog_nxt   = '0;
            seg_nxt    = '0;
            tick_nxt   = '0;
            lap_nxt    = '0;
          end
          REQ_STOP: begin
            run_nxt    = 1'b0;
            pause_nxt  = 1'b0;
            banked_nxt = '0;
            prog_nxt   = '0;
          end
          REQ_PAUSE: begin
            if (live) begin
              pause_nxt  = 1'b1;
              banked_nxt = sat_add(banked_r, seg_r);
            end
          end
          REQ_RESUME: begin
            if (run_r && pause_r) begin
              pause_nxt = 1'b0;
              seg_nxt   = '0;
              tick_nxt  = '0;
              lap_nxt   = '0;
            end
          end
          REQ_RESET: begin
            banked_nxt = '0;
            prog_nxt   = '0;
            if (live) begin
              seg_nxt  = '0;
              tick_nxt = '0;
              lap_nxt  = '0;
            end
          end
          REQ_TICK: begin
            if (live) begin
              delta_nxt = tick_r;
              tick_nxt  = '0;
            end
          end
          REQ_LAP: begin
            delta_nxt = lap_r;
            lap_nxt   = '0;
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        if (div_stat.done) begin
          prog_nxt  = div_rem;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we && ((cfg_index == CFG_INTERVAL) || (cfg_index == CFG_REPEAT))) begin
      prog_nxt = '0;
    end
  end

  pit_mod_unit #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (prog_sum),
    .divisor   (interval_r),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      run_r      <= 1'b0;
      pause_r    <= 1'b0;
      banked_r   <= '0;
      seg_r      <= '0;
      tick_r     <= '0;
      lap_r      <= '0;
      prog_r     <= '0;
      interval_r <= '0;
      repeat_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      run_r    <= run_nxt;
      pause_r  <= pause_nxt;
      banked_r <= banked_nxt;
      seg_r    <= seg_nxt;
      tick_r   <= tick_nxt;
      lap_r    <= lap_nxt;
      prog_r   <= prog_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INTERVAL: begin
            interval_r <= cfg_x[TIME_WIDTH-1:0];
          end
          CFG_REPEAT: begin
            repeat_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_req_type;
      dt_r  <= step_x[TIME_WIDTH-1:0];
    end
    delta_r <= delta_nxt;
    fired_r <= fired_nxt;
  end

  assign elapsed_now = live ? sat_add(banked_r, seg_r) : banked_r;
  assign elapsed_x   = OXW'(elapsed_now);
  assign delta_x     = OXW'(delta_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_elapsed_r <= elapsed_x[OUT_WIDTH-1:0];
      out_delta_r   <= delta_x[OUT_WIDTH-1:0];
      out_fired_r   <= fired_r;
      out_running_r <= run_r;
      out_paused_r  <= pause_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_elapsed    = out_elapsed_r;
  assign out_delta      = out_delta_r;
  assign out_fired      = out_fired_r;
  assign out_is_running = out_running_r;
  assign out_is_paused  = out_paused_r;

endmodule

`default_nettype wire

// File: sv/pit_checker.sv
// Port-level checker for the pausable interval timer, with its bind.
// Depends on pit_pkg for widths; attaches to pausable_interval_timer.
`default_nettype none

module pit_checker
  import pit_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [OUT_WIDTH-1:0] out_elapsed,
  input wire logic [OUT_WIDTH-1:0] out_delta,
  input wire logic                 out_fired,
  input wire logic                 out_is_running,
  input wire logic                 out_is_paused
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_elapsed) && $stable(out_delta))
    else $error("Stalled result item changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Block ready again right after accepting an item.");

  a_paused_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_is_paused || out_is_running)
    else $error("Result item reports paused while not running.");

  a_fired_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_delta == '0)
    else $error("Fired result item carries a nonzero delta.");

endmodule

bind pausable_interval_timer pit_checker u_pit_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_elapsed    (out_elapsed),
  .out_delta      (out_delta),
  .out_fired      (out_fired),
  .out_is_running (out_is_running),
  .out_is_paused  (out_is_paused)
);

`default_nettype wire

// File: dv/pit_timer_checker.sv
// Checker for the pausable interval timer: watches the request, result and register ports,
// keeps its own model of the timer and compares every result item field by field.
// Depends on pit_pkg for request codes, register indexes and widths.
`timescale 1ns / 100ps

module pit_timer_checker
  import pit_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [REQ_WIDTH-1:0]      in_req_type,
  input  logic [STEP_WIDTH_DEF-1:0] in_time_step,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [OUT_WIDTH-1:0]      out_elapsed,
  input  logic [OUT_WIDTH-1:0]      out_delta,
  input  logic                      out_fired,
  input  logic                      out_is_running,
  input  logic                      out_is_paused,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  output int                        error_count,
  output int                        outstanding
);

  typedef logic [TIME_WIDTH_DEF-1:0] ticks_t;

  typedef struct packed {
    ticks_t elapsed;
    ticks_t delta;
    logic   fired;
    logic   running;
    logic   paused;
  } timer_result_t;

  ticks_t        interval_len;
  logic          periodic;
  logic          running;
  logic          paused;
  ticks_t        banked;
  ticks_t        segment;
  ticks_t        since_tick;
  ticks_t        since_lap;
  ticks_t        progress;
  timer_result_t timer_results_q[$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  function automatic ticks_t clamp_sum(input ticks_t a, input ticks_t b);
    logic [TIME_WIDTH_DEF:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_WIDTH_DEF] ? '1 : sum[TIME_WIDTH_DEF-1:0];
  endfunction

  function automatic void zero_marks();
    segment    = '0;
    since_tick = '0;
    since_lap  = '0;
  endfunction

  function automatic void clear_timer();
    interval_len = '0;
    periodic     = 1'b0;
    running      = 1'b0;
    paused       = 1'b0;
    banked       = '0;
    progress     = '0;
    zero_marks();
  endfunction

  function automatic timer_result_t apply_request(input logic [REQ_WIDTH-1:0] req,
                                                  input ticks_t step);
    timer_result_t res;
    logic          live;
    res  = '0;
    live = running && !paused;
    case (req)
      REQ_ADVANCE: begin
        since_lap = clamp_sum(since_lap, step);
        if (live) begin
          segment    = clamp_sum(segment, step);
          since_tick = clamp_sum(since_tick, step);
          if (interval_len != '0) begin
            progress = clamp_sum(progress, step);
            if (progress >= interval_len) begin
              res.fired = 1'b1;
              if (periodic) begin
                progress = progress % interval_len;
              end else begin
                running  = 1'b0;
                progress = '0;
              end
            end
          end
        end
      end
      REQ_START: begin
        running  = 1'b1;
        paused   = 1'b0;
        banked   = '0;
        progress = '0;
        zero_marks();
      end
      REQ_STOP: begin
        running  = 1'b0;
        paused   = 1'b0;
        banked   = '0;
        progress = '0;
      end
      REQ_PAUSE: begin
        if (live) begin
          paused = 1'b1;
          banked = clamp_sum(banked, segment);
        end
      end
      REQ_RESUME: begin
        if (running && paused) begin
          paused = 1'b0;
          zero_marks();
        end
      end
      REQ_RESET: begin
        banked   = '0;
        progress = '0;
        if (live) zero_marks();
      end
      REQ_TICK: begin
        if (live) begin
          res.delta  = since_tick;
          since_tick = '0;
        end
      end
      REQ_LAP: begin
        res.delta = since_lap;
        since_lap = '0;
      end
    endcase
    res.elapsed = (running && !paused) ? clamp_sum(banked, segment) : banked;
    res.running = running;
    res.paused  = paused;
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count = error_count + 1;
  endtask

  always @(posedge clk) begin : monitor
    timer_result_t want;
    if (!rst_n) begin
      clear_timer();
      timer_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (timer_results_q.size() == 0) begin
          report_error("result item with no expectation waiting");
        end else begin
          want = timer_results_q.pop_front();
          if (out_elapsed !== want.elapsed)
            report_error($sformatf("elapsed %0d, expected %0d", out_elapsed, want.elapsed));
          if (out_delta !== want.delta)
            report_error($sformatf("delta %0d, expected %0d", out_delta, want.delta));
          if (out_fired !== want.fired)
            report_error($sformatf("fired %b, expected %b", out_fired, want.fired));
          if (out_is_running !== want.running)
            report_error($sformatf("is_running %b, expected %b", out_is_running,
                                   want.running));
          if (out_is_paused !== want.paused)
            report_error($sformatf("is_paused %b, expected %b", out_is_paused, want.paused));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERVAL: begin
            interval_len = cfg_data;
            progress     = '0;
          end
          CFG_REPEAT: begin
            periodic = cfg_data[0];
            progress = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        timer_results_q.push_back(apply_request(in_req_type, ticks_t'(in_time_step)));
    end
    outstanding = timer_results_q.size();
  end

endmodule

// File: dv/pausable_interval_timer_tb.sv
// Testbench top for the pausable interval timer: clock, reset, request and register stimulus,
// receiver stalls, watchdog and verdict. Depends on pit_pkg, pit_timer_checker and the block.
`timescale 1ns / 100ps

module pausable_interval_timer_tb;
  import pit_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [REQ_WIDTH-1:0]      in_req_type = REQ_ADVANCE;
  logic [STEP_WIDTH_DEF-1:0] in_time_step = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [OUT_WIDTH-1:0]      out_elapsed;
  logic [OUT_WIDTH-1:0]      out_delta;
  logic                      out_fired;
  logic                      out_is_running;
  logic                      out_is_paused;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index = CFG_INTERVAL;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  int error_count;
  int outstanding;
  int snd_idle_pct = 23;
  int rcv_idle_pct = 85;
  int hold_cycles = 0;
  int stall_cycles = 0;

  always #2 clk = ~clk;

  pausable_interval_timer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_time_step   (in_time_step),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_elapsed    (out_elapsed),
    .out_delta      (out_delta),
    .out_fired      (out_fired),
    .out_is_running (out_is_running),
    .out_is_paused  (out_is_paused),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  pit_timer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_time_step   (in_time_step),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_elapsed    (out_elapsed),
    .out_delta      (out_delta),
    .out_fired      (out_fired),
    .out_is_running (out_is_running),
    .out_is_paused  (out_is_paused),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .outstanding    (outstanding)
  );

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("pausable_interval_timer test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic [REQ_WIDTH-1:0] req,
                           input logic [STEP_WIDTH_DEF-1:0] step);
    @(negedge clk);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_time_step <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REQ_WIDTH-1:0] pick_request();
    int r;
    r = $urandom_range(99);
    if (r < 45) return REQ_ADVANCE;
    if (r < 52) return REQ_START;
    if (r < 57) return REQ_STOP;
    if (r < 65) return REQ_PAUSE;
    if (r < 73) return REQ_RESUME;
    if (r < 78) return REQ_RESET;
    if (r < 88) return REQ_TICK;
    return REQ_LAP;
  endfunction

  // A run of items after a fresh interval setting: mostly a live timer fed with
  // steps scaled to the interval, with some fully random items mixed in.
  task automatic run_segment(input int n_items);
    logic [CFG_DATA_WIDTH-1:0] interval_len;
    logic [31:0]               span;
    case ($urandom_range(5))
      0:       interval_len = '0;
      1:       interval_len = 32'd1;
      2:       interval_len = $urandom_range(40, 2);
      3:       interval_len = $urandom_range(5000, 41);
      4:       interval_len = '1;
      default: interval_len = $urandom();
    endcase
    write_reg(CFG_INTERVAL, interval_len);
    write_reg(CFG_REPEAT, $urandom_range(1));
    if (interval_len == '0) span = 200;
    else if (interval_len <= 20000) span = interval_len * 2;
    else span = 65535;
    send_item(REQ_START, STEP_WIDTH_DEF'($urandom()));
    for (int i = 1; i < n_items; i++) begin
      if ($urandom_range(99) < 12)
        send_item(REQ_WIDTH'($urandom_range(7)), STEP_WIDTH_DEF'($urandom()));
      else if ($urandom_range(7) == 0)
        send_item(pick_request(), STEP_WIDTH_DEF'($urandom_range(65535)));
      else
        send_item(pick_request(), STEP_WIDTH_DEF'($urandom_range(span)));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_item(REQ_ADVANCE, 16'hFFFF);
    send_item(REQ_TICK, 16'h0000);
    send_item(REQ_PAUSE, 16'h0000);
    send_item(REQ_RESUME, 16'h0000);
    send_item(REQ_START, 16'h0000);
    send_item(REQ_ADVANCE, 16'h0000);
    send_item(REQ_ADVANCE, 16'hFFFF);
    send_item(REQ_TICK, 16'h0000);
    send_item(REQ_PAUSE, 16'h0000);
    send_item(REQ_PAUSE, 16'h0000);
    send_item(REQ_ADVANCE, 16'd100);
    send_item(REQ_TICK, 16'h0000);
    send_item(REQ_RESUME, 16'h0000);
    send_item(REQ_RESUME, 16'h0000);
    send_item(REQ_LAP, 16'h0000);
    send_item(REQ_RESET, 16'h0000);
    send_item(REQ_ADVANCE, 16'd7);
    send_item(REQ_STOP, 16'h0000);
    send_item(REQ_LAP, 16'h0000);

    drain_results();
    write_reg(CFG_INTERVAL, 32'd5);
    write_reg(CFG_REPEAT, 32'd1);
    send_item(REQ_START, 16'h0000);
    send_item(REQ_ADVANCE, 16'd3);
    send_item(REQ_ADVANCE, 16'd14);
    send_item(REQ_ADVANCE, 16'hFFFF);

    drain_results();
    write_reg(CFG_REPEAT, 32'd0);
    send_item(REQ_START, 16'h0000);
    send_item(REQ_ADVANCE, 16'd5);

    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 5; seg++) begin
        drain_results();
        if (seg == 0) begin
          snd_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 85 : 0;
          rcv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 23 : 0;
        end
        if (phase == 2 && seg == 1) hold_cycles = 300;
        run_segment(47);
      end
    end

    // Long advances under the widest periodic interval, then the other commands.
    drain_results();
    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
    write_reg(CFG_REPEAT, 32'd1);
    send_item(REQ_START, 16'h0000);
    send_item(REQ_ADVANCE, 16'd1);
    repeat (16) send_item(REQ_ADVANCE, 16'hFFFF);
    send_item(REQ_TICK, 16'h0000);
    send_item(REQ_PAUSE, 16'h0000);
    send_item(REQ_ADVANCE, 16'd5);
    send_item(REQ_RESUME, 16'h0000);
    send_item(REQ_ADVANCE, 16'hFFFF);
    send_item(REQ_LAP, 16'h0000);
    send_item(REQ_RESET, 16'h0000);
    send_item(REQ_STOP, 16'h0000);

    drain_results();
    if (error_count == 0) begin
      $display("pausable_interval_timer test passed");
    end else begin
      $display("pausable_interval_timer test failed");
    end
    $finish;
  end

endmodule
